// ===== sv/assert_macros.svh =====
// assertion macros used by the one rtl file that checks itself, the receiver top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== sv/imu_tlv_pkg.sv =====
// shared types and constants of the tlv frame receiver
`default_nettype none
package imu_tlv_pkg;

    localparam logic [7:0] HDR_FIRST  = 8'h59;
    localparam logic [7:0] HDR_SECOND = 8'h53;

    localparam int N_VALS  = 10;
    localparam int POS_W   = 9;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // configuration register indexes
    localparam logic [1:0] CFG_ACCEL_TAG = 2'd0;
    localparam logic [1:0] CFG_RATE_TAG  = 2'd1;
    localparam logic [1:0] CFG_QUAT_TAG  = 2'd2;

    // value slots: ax ay az rx ry rz qw qx qy qz
    localparam logic [3:0] IDX_ACCEL = 4'd0;
    localparam logic [3:0] IDX_RATE  = 4'd3;
    localparam logic [3:0] IDX_QUAT  = 4'd6;
    localparam logic [7:0] LIMIT_VEC  = 8'd12;
    localparam logic [7:0] LIMIT_QUAT = 8'd16;

    typedef enum logic [1:0] {
        KIND_START,
        KIND_DATA,
        KIND_END
    } t_kind;

    // command from the framer to the record parser
    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
    } t_cmd;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [7:0]       len;
    } t_front_stat;

endpackage
`default_nettype wire

// ===== sv/imu_tlv_front.sv =====
// framer: header hunt, length, running check sums and check byte compare
`default_nettype none
module imu_tlv_front
    import imu_tlv_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic [7:0]  i_byte,
    output logic             o_ready,
    input  wire logic        i_full,
    output logic             o_push,
    output t_cmd             o_cmd,
    output t_front_stat      o_stat
);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_len, n_len;
    logic [7:0]       r_s1, n_s1;
    logic [7:0]       r_s2, n_s2;
    logic [7:0]       r_ck1, n_ck1;
    logic [POS_W-1:0] len_p4, len_p5;
    logic [7:0]       sum1, sum2;
    logic             take;

    assign o_ready = !i_full;
    assign take    = i_valid && o_ready;
    assign len_p4  = {1'b0, r_len} + POS_W'(4);
    assign len_p5  = {1'b0, r_len} + POS_W'(5);
    assign sum1    = r_s1 + i_byte;
    assign sum2    = r_s2 + sum1;

    always_comb begin
        n_pos  = r_pos;
        n_len  = r_len;
        n_s1   = r_s1;
        n_s2   = r_s2;
        n_ck1  = r_ck1;
        o_push = 1'b0;
        o_cmd  = '{kind: KIND_DATA, data: i_byte};
        if (take) begin
            priority if (r_pos == '0) begin
                if (i_byte == HDR_FIRST) n_pos = POS_W'(1);
            end else if (r_pos == POS_W'(1)) begin
                if (i_byte == HDR_SECOND) begin
                    n_pos  = POS_W'(2);
                    n_s1   = '0;
                    n_s2   = '0;
                    o_push = 1'b1;
                    o_cmd  = '{kind: KIND_START, data: 8'd0};
                end else if (i_byte != HDR_FIRST) begin
                    n_pos = '0;
                end
            end else if (r_pos <= len_p4 || r_pos <= POS_W'(4)) begin
                if (r_pos == POS_W'(4)) n_len = i_byte;
                n_s1  = sum1;
                n_s2  = sum2;
                // bytes after the length byte are payload
                o_push = (r_pos >= POS_W'(5));
                n_pos  = r_pos + POS_W'(1);
            end else if (r_pos == len_p5) begin
                n_ck1 = i_byte;
                n_pos = r_pos + POS_W'(1);
            end else begin
                n_pos  = '0;
                o_push = 1'b1;
                o_cmd  = '{kind: KIND_END,
                           data: {7'd0, !(r_s1 == r_ck1 && r_s2 == i_byte)}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_len <= '0;
            r_s1  <= '0;
            r_s2  <= '0;
            r_ck1 <= '0;
        end else begin
            r_pos <= n_pos;
            r_len <= n_len;
            r_s1  <= n_s1;
            r_s2  <= n_s2;
            r_ck1 <= n_ck1;
        end
    end

    assign o_stat = '{pos: r_pos, len: r_len};

endmodule
`default_nettype wire

// ===== sv/imu_tlv_queue.sv =====
// short command fifo between framer and record parser
`default_nettype none
module imu_tlv_queue
    import imu_tlv_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  t_cmd       i_cmd,
    input  wire logic  i_pop,
    output logic       o_full,
    output logic       o_empty,
    output t_cmd       o_head
);

    t_cmd              r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr, r_rd;
    logic [Q_AW:0]     r_cnt;
    logic              do_push, do_pop;

    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + Q_AW'(1);
            if (do_pop)  r_rd <= r_rd + Q_AW'(1);
            r_cnt <= r_cnt + (Q_AW+1)'(do_push) - (Q_AW+1)'(do_pop);
        end
    end

endmodule
`default_nettype wire

// ===== sv/imu_tlv_back.sv =====
// record parser: tag/length walk, value capture, commit and result register
`default_nettype none
module imu_tlv_back
    import imu_tlv_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic        i_empty,
    input  t_cmd             i_head,
    output logic             o_pop,
    output logic             o_pop_end,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_status,
    output logic [31:0]      o_vals [N_VALS]
);

    logic [7:0]  r_accel_tag, r_rate_tag, r_quat_tag;
    logic [7:0]  r_off, n_off;
    logic [7:0]  r_tag, n_tag;
    logic [7:0]  r_rem, n_rem;
    logic [31:0] r_pend [N_VALS];
    logic [31:0] n_pend [N_VALS];
    logic [31:0] r_comm [N_VALS];
    logic [31:0] r_out  [N_VALS];
    logic        r_out_valid, r_status;

    logic [7:0]  d, b;
    logic        hit;
    logic [3:0]  base, idx;
    logic [7:0]  limit;
    logic [4:0]  sh;
    logic        is_end, bad;

    assign b      = i_head.data;
    assign is_end = (i_head.kind == KIND_END);
    assign bad    = i_head.data[0];
    // a result waits only for room in the output register
    assign o_pop     = !i_empty && (!is_end || !r_out_valid || i_out_ready);
    assign o_pop_end = o_pop && is_end;

    assign d   = r_off - 8'd2;
    assign idx = base + {2'b00, d[3:2]};
    assign sh  = {d[1:0], 3'b000};

    always_comb begin
        hit   = 1'b1;
        base  = IDX_ACCEL;
        limit = LIMIT_VEC;
        priority if (r_tag == r_accel_tag) begin
            base = IDX_ACCEL;
        end else if (r_tag == r_rate_tag) begin
            base = IDX_RATE;
        end else if (r_tag == r_quat_tag) begin
            base  = IDX_QUAT;
            limit = LIMIT_QUAT;
        end else begin
            hit = 1'b0;
        end
    end

    always_comb begin
        n_off  = r_off;
        n_tag  = r_tag;
        n_rem  = r_rem;
        n_pend = r_pend;
        if (o_pop) begin
            unique case (i_head.kind)
                KIND_START: begin
                    n_off  = '0;
                    n_tag  = '0;
                    n_rem  = '0;
                    n_pend = r_comm;
                end
                KIND_DATA: begin
                    priority if (r_off == 8'd0) begin
                        n_tag = b;
                        n_off = 8'd1;
                    end else if (r_off == 8'd1) begin
                        n_rem = b;
                        n_off = (b == 8'd0) ? 8'd0 : 8'd2;
                    end else begin
                        for (int k = 0; k < N_VALS; k++) begin
                            if (hit && d < limit && idx == 4'(k))
                                n_pend[k][sh +: 8] = b;
                        end
                        n_rem = r_rem - 8'd1;
                        if (n_rem == 8'd0) n_off = 8'd0;
                        else if (r_off != 8'hff) n_off = r_off + 8'd1;
                    end
                end
                KIND_END: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_tag <= 8'd16;
            r_rate_tag  <= 8'd32;
            r_quat_tag  <= 8'd65;
            r_off       <= '0;
            r_tag       <= '0;
            r_rem       <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < N_VALS; k++) begin
                r_pend[k] <= '0;
                r_comm[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ACCEL_TAG: r_accel_tag <= i_cfg_data;
                    CFG_RATE_TAG:  r_rate_tag  <= i_cfg_data;
                    CFG_QUAT_TAG:  r_quat_tag  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            r_off  <= n_off;
            r_tag  <= n_tag;
            r_rem  <= n_rem;
            r_pend <= n_pend;
            if (o_pop_end && !bad) r_comm <= r_pend;
            if (o_pop_end) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (o_pop_end) begin
            r_status <= bad;
            r_out    <= bad ? r_comm : r_pend;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_vals      = r_out;

endmodule
`default_nettype wire

// ===== sv/imu_tlv_frame_receiver_top.sv =====
// Tag-length-value frame receiver for an inertial sensor byte stream. One byte is
// taken per clock while the command queue has room; the framer turns it into at
// most one command and the record parser retires one command per clock, so the
// sustained rate is one byte per cycle. Input stalls only when a finished
// result sits unread in the output register and the four-entry queue behind it
// has filled. A result follows the second check byte with the status plus the
// ten latest committed values. Tag registers are written through the plain write
// port, by the user only while no frame is in flight; nothing enforces this.
`default_nettype none
`include "assert_macros.svh"
module imu_tlv_frame_receiver_top
    import imu_tlv_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [7:0]         i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [7:0]         i_rx_byte,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic                    o_frame_status,
    output logic signed [31:0]      o_accel_x,
    output logic signed [31:0]      o_accel_y,
    output logic signed [31:0]      o_accel_z,
    output logic signed [31:0]      o_rate_x,
    output logic signed [31:0]      o_rate_y,
    output logic signed [31:0]      o_rate_z,
    output logic signed [31:0]      o_quat_w,
    output logic signed [31:0]      o_quat_x,
    output logic signed [31:0]      o_quat_y,
    output logic signed [31:0]      o_quat_z
);

    logic        w_push, w_pop, w_pop_end, w_full, w_empty;
    t_cmd        w_cmd, w_head;
    t_front_stat w_fstat;
    logic [31:0] w_vals [N_VALS];

    imu_tlv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_byte  (i_rx_byte),
        .o_ready (o_in_ready),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_cmd   (w_cmd),
        .o_stat  (w_fstat)
    );

    imu_tlv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    imu_tlv_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_empty     (w_empty),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_pop_end   (w_pop_end),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_status    (o_frame_status),
        .o_vals      (w_vals)
    );

    assign o_accel_x = w_vals[0];
    assign o_accel_y = w_vals[1];
    assign o_accel_z = w_vals[2];
    assign o_rate_x  = w_vals[3];
    assign o_rate_y  = w_vals[4];
    assign o_rate_z  = w_vals[5];
    assign o_quat_w  = w_vals[6];
    assign o_quat_x  = w_vals[7];
    assign o_quat_y  = w_vals[8];
    assign o_quat_z  = w_vals[9];

    // no command may be lost to a full queue
    `ASSERT_IMPLIES(a_no_overflow, w_full, !w_push, "command pushed into full queue")
    // frame position never runs past the second check byte
    `ASSERT_ALWAYS(a_pos_bound, w_fstat.pos <= ({1'b0, w_fstat.len} + POS_W'(6)),
        "frame position beyond check bytes")
    // a result shows up only after an end-of-frame command was retired
    `ASSERT_IMPLIES(a_result_source, $rose(o_out_valid), $past(w_pop_end),
        "result without end of frame")

endmodule
`default_nettype wire
